// ===== sv/chbt_pkg.sv =====
package chbt_pkg;

    // Table geometry
    localparam int BUCKETS = 10;
    localparam int SLOTS   = 8;
    localparam int DEPTH   = BUCKETS * SLOTS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int REM_W   = $clog2(BUCKETS);

    // Word field widths
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 31;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 4;
    localparam int CNT_MAX = 15;

    // Key modulus: HASH_DIG key bits folded into the remainder per cycle
    localparam int HASH_DIG   = 8;
    localparam int HASH_STEPS = (KEY_W + HASH_DIG - 1) / HASH_DIG;
    localparam int HKEY_W     = HASH_STEPS * HASH_DIG;
    localparam int HCNT_W     = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_BASE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic hash_step;
        logic base_load;
        logic scan;
        logic out_load;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic is_insert;
        logic is_nop;
        logic hash_done;
        logic scan_last;
        logic ins_free;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== sv/chained_hash_bucket_table.sv =====
// Hash table of BUCKETS buckets with SLOTS value slots each; a word's key picks
// bucket key mod BUCKETS. Insert fills the lowest free slot (overflow=1 when
// full), find reports found, remove clears every equal entry and reports
// removed_count. Every word returns exactly one result; an unused command
// changes nothing and returns all zeros. One word is processed at a time:
// the word is accepted, the key remainder is formed 8 key bits per cycle,
// the bucket base is formed, then the bucket is walked one slot per cycle
// through the single-port slot store: insert stops at the first free slot,
// find/remove walk every slot, and an unused command skips the walk; the
// result then waits for the result register to drain. The table is empty
// right after reset, with no clearing pass.
module chained_hash_bucket_table (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic        [chbt_pkg::CMD_W-1:0]    command,
    input  logic        [chbt_pkg::KEY_W-1:0]    key,
    input  logic signed [chbt_pkg::VAL_W-1:0]    value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 found,
    output logic                                 overflow,
    output logic        [chbt_pkg::CNT_W-1:0]    removed_count
);

    chbt_pkg::ctrl_cmd_t  cmd;
    chbt_pkg::dp_status_t status;

    chbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    chbt_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .command       (command),
        .key           (key),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .overflow      (overflow),
        .removed_count (removed_count),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

// ===== sv/chbt_ctrl.sv =====
module chbt_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  chbt_pkg::dp_status_t   status,
    output chbt_pkg::ctrl_cmd_t    cmd
);

    chbt_pkg::state_t state_reg;
    chbt_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chbt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            chbt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = chbt_pkg::ST_HASH;
                end
            end
            chbt_pkg::ST_HASH:
            begin
                if (status.is_nop)
                begin
                    state_next = chbt_pkg::ST_DONE;
                end
                else if (status.hash_done)
                begin
                    state_next = chbt_pkg::ST_BASE;
                end
            end
            chbt_pkg::ST_BASE:
            begin
                state_next = chbt_pkg::ST_SCAN;
            end
            chbt_pkg::ST_SCAN:
            begin
                if (status.is_insert)
                begin
                    if (status.ins_free || status.scan_last)
                    begin
                        state_next = chbt_pkg::ST_DONE;
                    end
                end
                else if (status.scan_last)
                begin
                    state_next = chbt_pkg::ST_DRAIN;
                end
            end
            chbt_pkg::ST_DRAIN:
            begin
                state_next = chbt_pkg::ST_DONE;
            end
            chbt_pkg::ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = chbt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = chbt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            chbt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            chbt_pkg::ST_HASH:
            begin
                cmd.hash_step = !status.is_nop;
            end
            chbt_pkg::ST_BASE:
            begin
                cmd.base_load = 1'b1;
            end
            chbt_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            chbt_pkg::ST_DONE:
            begin
                cmd.out_load = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/chbt_dp.sv =====
module chbt_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic        [chbt_pkg::CMD_W-1:0]    command,
    input  logic        [chbt_pkg::KEY_W-1:0]    key,
    input  logic signed [chbt_pkg::VAL_W-1:0]    value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 found,
    output logic                                 overflow,
    output logic        [chbt_pkg::CNT_W-1:0]    removed_count,
    input  chbt_pkg::ctrl_cmd_t                  cmd,
    output chbt_pkg::dp_status_t                 status
);

    // Captured word
    logic [chbt_pkg::CMD_W-1:0]  cmd_reg;
    logic [chbt_pkg::VAL_W-1:0]  val_reg;
    logic [chbt_pkg::HKEY_W-1:0] hkey_reg;
    logic [chbt_pkg::HKEY_W-1:0] hkey_next;
    logic [chbt_pkg::HCNT_W-1:0] hcnt_reg;
    logic [chbt_pkg::REM_W-1:0]  rem_reg;
    logic [chbt_pkg::REM_W-1:0]  rem_next;

    // Scan state
    logic [chbt_pkg::ADDR_W-1:0] base_reg;
    logic [chbt_pkg::SLOT_W-1:0] slot_reg;
    logic [chbt_pkg::ADDR_W-1:0] addr;
    logic                        cmp_pend_reg;
    logic [chbt_pkg::ADDR_W-1:0] cmp_addr_reg;
    logic [chbt_pkg::VAL_W-1:0]  rd_data_reg;
    logic                        hit;
    logic                        is_insert;
    logic                        is_find;
    logic                        is_remove;
    logic                        ins_write;

    // Slot store and occupancy
    logic [chbt_pkg::VAL_W-1:0]  slot_mem [chbt_pkg::DEPTH];
    logic [chbt_pkg::DEPTH-1:0]  valid_reg;

    // Per-word results and output register
    logic                        found_reg;
    logic                        ovf_reg;
    logic [chbt_pkg::CNT_W-1:0]  cnt_reg;
    logic                        out_valid_reg;
    logic                        out_found_reg;
    logic                        out_ovf_reg;
    logic [chbt_pkg::CNT_W-1:0]  out_cnt_reg;

    assign is_insert = (cmd_reg == chbt_pkg::CMD_INSERT);
    assign is_find   = (cmd_reg == chbt_pkg::CMD_FIND);
    assign is_remove = (cmd_reg == chbt_pkg::CMD_REMOVE);

    // Remainder: fold HASH_DIG key bits, MSB first, one restoring step each
    always_comb
    begin
        logic [chbt_pkg::REM_W:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < chbt_pkg::HASH_DIG; i++)
        begin
            r = {r[chbt_pkg::REM_W-1:0], hkey_reg[chbt_pkg::HKEY_W-1-i]};
            if (r >= (chbt_pkg::REM_W+1)'(chbt_pkg::BUCKETS))
            begin
                r = r - (chbt_pkg::REM_W+1)'(chbt_pkg::BUCKETS);
            end
        end
        rem_next  = r[chbt_pkg::REM_W-1:0];
        hkey_next = hkey_reg << chbt_pkg::HASH_DIG;
    end

    assign addr      = base_reg + chbt_pkg::ADDR_W'(slot_reg);
    assign ins_write = cmd.scan && is_insert && !valid_reg[addr];
    assign hit       = cmp_pend_reg && valid_reg[cmp_addr_reg]
                       && (rd_data_reg == val_reg);

    // Status
    always_comb
    begin
        status.is_insert = is_insert;
        status.is_nop    = !(cmd_reg inside {chbt_pkg::CMD_INSERT, chbt_pkg::CMD_FIND,
                                             chbt_pkg::CMD_REMOVE});
        status.hash_done = (hcnt_reg == chbt_pkg::HCNT_W'(chbt_pkg::HASH_STEPS - 1));
        status.scan_last = (slot_reg == chbt_pkg::SLOT_W'(chbt_pkg::SLOTS - 1));
        status.ins_free  = !valid_reg[addr];
        status.out_busy  = out_valid_reg && !out_ready;
    end

    // Word capture, remainder and slot walk
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= command;
            val_reg  <= value;
            hkey_reg <= chbt_pkg::HKEY_W'(key);
            hcnt_reg <= '0;
            rem_reg  <= '0;
        end
        else if (cmd.hash_step)
        begin
            hkey_reg <= hkey_next;
            rem_reg  <= rem_next;
            hcnt_reg <= hcnt_reg + 1'b1;
        end
        if (cmd.base_load)
        begin
            base_reg <= chbt_pkg::ADDR_W'(int'(rem_reg) * chbt_pkg::SLOTS);
            slot_reg <= '0;
        end
        else if (cmd.scan)
        begin
            slot_reg <= slot_reg + 1'b1;
        end
        cmp_addr_reg <= addr;
    end

    // Slot store: one address per cycle, read every cycle and also written on an insert
    always_ff @(posedge clk)
    begin
        if (ins_write)
        begin
            slot_mem[addr] <= val_reg;
        end
        rd_data_reg <= slot_mem[addr];
    end

    // Occupancy, compare stage and per-word results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            cmp_pend_reg <= 1'b0;
            found_reg    <= 1'b0;
            ovf_reg      <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            cmp_pend_reg <= cmd.scan && (is_find || is_remove);
            if (cmd.load)
            begin
                found_reg <= 1'b0;
                ovf_reg   <= 1'b0;
                cnt_reg   <= '0;
            end
            else
            begin
                if (ins_write)
                begin
                    valid_reg[addr] <= 1'b1;
                end
                if (cmd.scan && is_insert && valid_reg[addr] && status.scan_last)
                begin
                    ovf_reg <= 1'b1;
                end
                if (hit && is_find)
                begin
                    found_reg <= 1'b1;
                end
                if (hit && is_remove)
                begin
                    valid_reg[cmp_addr_reg] <= 1'b0;
                    if (cnt_reg != chbt_pkg::CNT_W'(chbt_pkg::CNT_MAX))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_found_reg <= found_reg;
            out_ovf_reg   <= ovf_reg;
            out_cnt_reg   <= cnt_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = out_found_reg;
    assign overflow      = out_ovf_reg;
    assign removed_count = out_cnt_reg;

endmodule

// ===== bench/chained_hash_bucket_table_test.sv =====
`timescale 1ns / 100ps

module chained_hash_bucket_table_test;

    // Code that the block must ignore
    localparam logic [chbt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 300;
    localparam int RANDOM_WORDS = 1000;
    localparam int POOL_SIZE    = 12;
    // Largest multiplier that keeps hi * BUCKETS + bucket within the key range
    localparam int unsigned KEY_HI_MAX =
        (32'h7FFF_FFFF - (chbt_pkg::BUCKETS - 1)) / chbt_pkg::BUCKETS;

    typedef struct packed {
        logic                       found;
        logic                       overflow;
        logic [chbt_pkg::CNT_W-1:0] removed_count;
    } reply_t;

    // Shadow copy of the slot store plus the replies still owed by the block
    class hash_table_tracker;
        logic [chbt_pkg::VAL_W-1:0] shadow_value [chbt_pkg::DEPTH];
        bit                         shadow_used  [chbt_pkg::DEPTH];
        reply_t                     expected_replies [$];
        int                         errors;

        function new();
            foreach (shadow_used[i])
                shadow_used[i] = 1'b0;
            errors = 0;
        endfunction

        // Apply one word to the shadow table and return the reply it causes
        function reply_t predict_reply(logic [chbt_pkg::CMD_W-1:0] cmd,
                                       logic [chbt_pkg::KEY_W-1:0] k,
                                       logic [chbt_pkg::VAL_W-1:0] v);
            reply_t      r;
            int unsigned kk;
            int unsigned base;
            int          s;
            bit          placed;
            r      = '0;
            placed = 1'b0;
            kk     = {1'b0, k};
            base   = (kk % chbt_pkg::BUCKETS) * chbt_pkg::SLOTS;
            case (cmd)
                chbt_pkg::CMD_INSERT:
                begin
                    // lowest free slot takes the value
                    for (s = 0; s < chbt_pkg::SLOTS && !placed; s++)
                    begin
                        if (!shadow_used[base + s])
                        begin
                            shadow_used[base + s]  = 1'b1;
                            shadow_value[base + s] = v;
                            placed = 1'b1;
                        end
                    end
                    r.overflow = !placed;
                end
                chbt_pkg::CMD_FIND:
                begin
                    for (s = 0; s < chbt_pkg::SLOTS; s++)
                        if (shadow_used[base + s] && shadow_value[base + s] == v)
                            r.found = 1'b1;
                end
                chbt_pkg::CMD_REMOVE:
                begin
                    // every equal entry goes; count saturates
                    for (s = 0; s < chbt_pkg::SLOTS; s++)
                    begin
                        if (shadow_used[base + s] && shadow_value[base + s] == v)
                        begin
                            shadow_used[base + s] = 1'b0;
                            if (r.removed_count < chbt_pkg::CNT_MAX)
                                r.removed_count = r.removed_count + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_word(logic [chbt_pkg::CMD_W-1:0] cmd,
                                logic [chbt_pkg::KEY_W-1:0] k,
                                logic [chbt_pkg::VAL_W-1:0] v);
            expected_replies = {expected_replies, predict_reply(cmd, k, v)};
        endfunction

        function void check_result(reply_t got);
            reply_t want;
            if (expected_replies.size() == 0)
            begin
                $error("result word with no word outstanding");
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            if (got.found !== want.found)
            begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                errors++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
                errors++;
            end
            if (got.removed_count !== want.removed_count)
            begin
                $error("removed_count: expected %0d, actual %0d",
                       want.removed_count, got.removed_count);
                errors++;
            end
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_ready;
    logic        [chbt_pkg::CMD_W-1:0] command;
    logic        [chbt_pkg::KEY_W-1:0] key;
    logic signed [chbt_pkg::VAL_W-1:0] value;
    logic                              out_valid;
    logic                              out_ready;
    logic                              found;
    logic                              overflow;
    logic        [chbt_pkg::CNT_W-1:0] removed_count;

    hash_table_tracker          tracker;
    bit                         tx_steady;
    logic [chbt_pkg::VAL_W-1:0] value_pool [POOL_SIZE];

    chained_hash_bucket_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .key           (key),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .overflow      (overflow),
        .removed_count (removed_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one word after a random gap, or none while tx_steady is set, and hold it until taken
    task automatic send_word(input logic [chbt_pkg::CMD_W-1:0] cmd,
                             input logic [chbt_pkg::KEY_W-1:0] k,
                             input logic [chbt_pkg::VAL_W-1:0] v);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        key      <= k;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        tracker.note_word(cmd, k, v);
    endtask

    // Stimulus
    initial
    begin
        int                         i;
        int                         pick;
        int unsigned                bucket;
        int unsigned                kv;
        logic [chbt_pkg::CMD_W-1:0] cmd;
        logic [chbt_pkg::VAL_W-1:0] v;

        tracker   = new();
        tx_steady = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = chbt_pkg::CMD_INSERT;
        key       = '0;
        value     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // empty table
        send_word(chbt_pkg::CMD_FIND,   31'd0, 32'h0000_0000);
        send_word(chbt_pkg::CMD_REMOVE, 31'd0, 32'h0000_0000);
        // fill bucket 0, duplicates included, then one more to overflow
        send_word(chbt_pkg::CMD_INSERT, 31'd0,  32'h8000_0000);
        send_word(chbt_pkg::CMD_INSERT, 31'd10, 32'h7FFF_FFFF);
        send_word(chbt_pkg::CMD_INSERT, 31'd20, 32'hFFFF_FFFF);
        send_word(chbt_pkg::CMD_INSERT, 31'd30, 32'hFFFF_FFFF);
        send_word(chbt_pkg::CMD_INSERT, 31'd40, 32'h0000_0000);
        send_word(chbt_pkg::CMD_INSERT, 31'd50, 32'h0000_0001);
        send_word(chbt_pkg::CMD_INSERT, 31'd60, 32'h0000_0002);
        send_word(chbt_pkg::CMD_INSERT, 31'd70, 32'h0000_0003);
        send_word(chbt_pkg::CMD_INSERT, 31'd80, 32'h0000_0005);
        // same bucket from a large key, then a different bucket
        send_word(chbt_pkg::CMD_FIND,   31'd2147483640, 32'h8000_0000);
        send_word(chbt_pkg::CMD_FIND,   31'd2147483647, 32'h8000_0000);
        // remove a duplicated value, then reuse the freed slot
        send_word(chbt_pkg::CMD_REMOVE, 31'd0, 32'hFFFF_FFFF);
        send_word(chbt_pkg::CMD_FIND,   31'd0, 32'hFFFF_FFFF);
        send_word(chbt_pkg::CMD_INSERT, 31'd0, 32'h0000_0009);
        // ignored command
        send_word(CMD_UNUSED, 31'd0, 32'hFFFF_FFFF);
        send_word(CMD_UNUSED, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(chbt_pkg::CMD_INSERT, 31'h7FFF_FFFF, 32'h0000_0000);
        send_word(chbt_pkg::CMD_FIND,   31'h7FFF_FFFF, 32'h0000_0000);
        send_word(chbt_pkg::CMD_REMOVE, 31'd7, 32'h0000_0000);
        send_word(chbt_pkg::CMD_REMOVE, 31'd0, 32'h7FFF_FFFF);

        // small value pool so finds and removes hit stored entries
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        for (i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom();

        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            tx_steady = ((i / 80) % 3 == 1);
            pick = $urandom_range(0, 99);
            if (pick < 42)
                cmd = chbt_pkg::CMD_INSERT;
            else if (pick < 70)
                cmd = chbt_pkg::CMD_FIND;
            else if (pick < 95)
                cmd = chbt_pkg::CMD_REMOVE;
            else
                cmd = CMD_UNUSED;
            if ($urandom_range(0, 99) < 85)
            begin
                bucket = $urandom_range(0, chbt_pkg::BUCKETS - 1);
                kv     = $urandom_range(0, KEY_HI_MAX) * chbt_pkg::BUCKETS + bucket;
            end
            else
                kv = $urandom() & 32'h7FFF_FFFF;
            if ($urandom_range(0, 99) < 75)
                v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                v = $urandom();
            send_word(cmd, kv[chbt_pkg::KEY_W-1:0], v);
        end

        @(negedge clk) in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("chained_hash_bucket_table_test: PASS");
        else
            $display("chained_hash_bucket_table_test: FAIL");
        $finish;
    end

    // Result side: random stalls, steady stretches, one long hold-off
    initial
    begin
        int     stall;
        int     results_seen;
        reply_t got;
        out_ready    = 1'b0;
        results_seen = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (results_seen == HOLD_AT)
                stall = HOLD_CYCLES;
            else if ((results_seen / 60) % 3 == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 7);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.found         = found;
            got.overflow      = overflow;
            got.removed_count = removed_count;
            tracker.check_result(got);
            results_seen++;
        end
    end

    // Watchdog: too long without any word moving on either side
    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("chained_hash_bucket_table_test: FAIL");
        $finish;
    end

endmodule

// ===== chained_hash_bucket_table.f =====
sv/chbt_pkg.sv
sv/chbt_ctrl.sv
sv/chbt_dp.sv
sv/chained_hash_bucket_table.sv
bench/chained_hash_bucket_table_test.sv
